// ===== design/mbe_pkg.sv =====
// Package for the escape-time unit: control word layout, microprogram
// addresses, condition codes, the microcode table and fixed constants.
// No dependencies.
package mbe_pkg;

  // Width and reset value of the iteration limit register.
  localparam int unsigned LIMIT_W = 16;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd1000;

  // Microprogram addresses.
  typedef logic [1:0] upc_t;
  localparam upc_t UA_IDLE   = 2'd0;
  localparam upc_t UA_CHECK  = 2'd1;
  localparam upc_t UA_UPDATE = 2'd2;
  localparam upc_t UA_DONE   = 2'd3;

  // Sequencing conditions. Wait conditions hold the step until their event
  // and then go to the target; jump conditions go to the target when true
  // and otherwise fall through to the next step.
  typedef enum logic [2:0] {
    C_NEXT       = 3'd0,
    C_WAIT_IN    = 3'd1,
    C_WAIT_OUT   = 3'd2,
    C_JUMP_STOP  = 3'd3,
    C_JUMP_NOESC = 3'd4
  } cond_t;

  // One control word.
  typedef struct packed {
    logic  ld_point;  // take a new point from the input channel
    logic  mul_en;    // limit and range test, form the three products
    logic  upd_en;    // |z|^2 test, then new z and step count
    logic  emit;      // move the result into the output register
    cond_t cond;
    upc_t  target;
  } ctrl_t;

  // Status flags returned by the datapath to the sequencer.
  typedef struct packed {
    logic stop;      // limit reached or z out of range
    logic sum_esc;   // sum of squares exceeds four
    logic out_free;  // output register can take a result this cycle
  } status_t;

  // The microprogram.
  function automatic ctrl_t ucode_rom(input upc_t addr);
    ctrl_t cw;
    cw = '{ld_point: 1'b0, mul_en: 1'b0, upd_en: 1'b0, emit: 1'b0,
           cond: C_NEXT, target: UA_IDLE};
    case (addr)
      UA_IDLE: begin
        cw.ld_point = 1'b1;
        cw.cond     = C_WAIT_IN;
        cw.target   = UA_CHECK;
      end
      UA_CHECK: begin
        cw.mul_en = 1'b1;
        cw.cond   = C_JUMP_STOP;
        cw.target = UA_DONE;
      end
      UA_UPDATE: begin
        cw.upd_en = 1'b1;
        cw.cond   = C_JUMP_NOESC;
        cw.target = UA_CHECK;
      end
      UA_DONE: begin
        cw.emit   = 1'b1;
        cw.cond   = C_WAIT_OUT;
        cw.target = UA_IDLE;
      end
      default: begin
        cw.cond   = C_NEXT;
        cw.target = UA_IDLE;
      end
    endcase
    return cw;
  endfunction

endpackage

// ===== design/mandelbrot_escape_time.sv =====
// Top level of the escape-time unit: iteration limit register, microcode
// sequencer and datapath. Depends on mbe_pkg, mbe_sequencer and mbe_datapath.
//
// Usage: a request on the input channel (in_valid, in_stall) carries one
// point c as two signed fixed-point parts, in_c_real and in_c_imag. The
// block answers with one result on the output channel (out_valid,
// out_stall): the number of steps taken and whether the point escaped.
// The iteration limit is written through cfg_valid / cfg_ready / cfg_wdata
// while the block is idle; cfg_ready is always high.
// Timing: a request is taken in the idle step only. Each iteration runs two
// steps on the three multipliers: limit and range test with the products,
// then the |z|^2 test and the update. A point that stops at the limit or on
// the range test goes from the check step to the done step, one that fails
// the |z|^2 test from the update step; the done step moves the result into
// the output register and returns to idle, where the next request is taken.
// A stalled result waits in the output register; the block may finish its
// next point meanwhile and then waits until the register is free.
// Reset (rst_n low, synchronous) holds in_stall high, returns the sequencer
// to idle, empties the output register and sets the limit to 1000.
module mandelbrot_escape_time
  import mbe_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH   = 32,
  parameter int unsigned FRACTION_BITS = 28
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [VALUE_WIDTH-1:0] in_c_real,
  input  logic signed [VALUE_WIDTH-1:0] in_c_imag,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic        [LIMIT_W-1:0]     out_iteration_count,
  output logic                          out_escaped,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic        [LIMIT_W-1:0]     cfg_wdata
);

  logic [LIMIT_W-1:0] max_iter_r;
  ctrl_t              cw;
  status_t            st;

  // Iteration limit register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_iter_r <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_iter_r <= cfg_wdata;
    end
  end

  // Control.
  mbe_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .st       (st),
    .cw       (cw),
    .in_stall (in_stall)
  );

  // Arithmetic and result register.
  mbe_datapath #(
    .VALUE_WIDTH   (VALUE_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cw                  (cw),
    .in_valid            (in_valid),
    .in_c_real           (in_c_real),
    .in_c_imag           (in_c_imag),
    .max_iter            (max_iter_r),
    .out_stall           (out_stall),
    .st                  (st),
    .out_valid           (out_valid),
    .out_iteration_count (out_iteration_count),
    .out_escaped         (out_escaped)
  );

endmodule

// ===== design/mbe_sequencer.sv =====
// Microcode sequencer: step counter, control store lookup and branching.
// Depends on mbe_pkg for the control word, status flags and microprogram.
module mbe_sequencer
  import mbe_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  status_t st,
  output ctrl_t   cw,
  output logic    in_stall
);

  upc_t upc_r;
  upc_t upc_nxt;

  // Control word of the current step; no request is taken during reset.
  assign cw       = ucode_rom(upc_r);
  assign in_stall = !cw.ld_point || !rst_n;

  // Next step selection.
  always_comb begin
    case (cw.cond)
      C_WAIT_IN:    upc_nxt = in_valid    ? cw.target : upc_r;
      C_WAIT_OUT:   upc_nxt = st.out_free ? cw.target : upc_r;
      C_JUMP_STOP:  upc_nxt = st.stop     ? cw.target : upc_t'(upc_r + 2'd1);
      C_JUMP_NOESC: upc_nxt = !st.sum_esc ? cw.target : upc_t'(upc_r + 2'd1);
      default:      upc_nxt = upc_t'(upc_r + 2'd1);
    endcase
  end

  // Step counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= UA_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // An accepted request always starts with the limit and range test.
  a_accept_to_check: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (upc_r == UA_CHECK))
    else $error("accepted request did not enter the check step");

  // Once the result is handed over the sequencer returns to idle.
  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (upc_r == UA_DONE && st.out_free) |=> (upc_r == UA_IDLE))
    else $error("sequencer did not return to idle after the result");
`endif

endmodule

// ===== design/mbe_datapath.sv =====
// Escape-time datapath: point and z registers, squaring and cross-product
// multipliers, saturating update, step counter and the output register.
// Depends on mbe_pkg for the control word and status flags.
module mbe_datapath
  import mbe_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH   = 32,
  parameter int unsigned FRACTION_BITS = 28
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ctrl_t                         cw,
  input  logic                          in_valid,
  input  logic signed [VALUE_WIDTH-1:0] in_c_real,
  input  logic signed [VALUE_WIDTH-1:0] in_c_imag,
  input  logic        [LIMIT_W-1:0]     max_iter,
  input  logic                          out_stall,
  output status_t                       st,
  output logic                          out_valid,
  output logic        [LIMIT_W-1:0]     out_iteration_count,
  output logic                          out_escaped
);

  localparam int unsigned W  = VALUE_WIDTH;
  localparam int unsigned F  = FRACTION_BITS;
  localparam int unsigned EW = W + 2;      // headroom for the sums
  localparam int unsigned MW = F + 2;      // magnitude of z when |z| <= 2
  localparam int unsigned SW = F + 4;      // truncated square
  localparam int unsigned XW = F + 5;      // truncated doubled cross term

  localparam logic signed [W-1:0]  TWO  = {{(W-F-2){1'b0}}, 1'b1, {(F+1){1'b0}}};
  localparam logic signed [W-1:0]  NTWO = -TWO;
  localparam logic        [XW-1:0] FOUR = {3'b001, {(F+2){1'b0}}};
  localparam logic signed [EW-1:0] VMAX = {3'b000, {(W-1){1'b1}}};
  localparam logic signed [EW-1:0] VMIN = {3'b111, {(W-1){1'b0}}};

  logic signed [W-1:0]   cr_r, ci_r, zr_r, zi_r;
  logic signed [W-1:0]   zr_nxt, zi_nxt;
  logic [LIMIT_W-1:0]    n_r;
  logic                  esc_r;
  logic [SW-1:0]         sr_r, si_r;
  logic [XW-1:0]         cross_r;
  logic                  xneg_r;
  logic                  out_valid_r;
  logic [LIMIT_W-1:0]    out_count_r;
  logic                  out_esc_r;

  logic                  load, emit_go;
  logic                  limit_hit, out_of_range;
  logic [W-1:0]          zr_mag, zi_mag;
  logic [MW-1:0]         ur, ui;
  logic [2*MW-1:0]       p_rr, p_ii, p_ri;
  logic [XW-1:0]         sum_sq;
  logic signed [EW-1:0]  zr_sum, zi_sum, xc;

  assign load    = cw.ld_point && in_valid;
  assign emit_go = cw.emit && st.out_free;

  // Limit and range test, magnitudes and the three products.
  always_comb begin
    limit_hit    = (n_r >= max_iter);
    out_of_range = (zr_r > TWO) || (zr_r < NTWO) || (zi_r > TWO) || (zi_r < NTWO);
    zr_mag       = zr_r[W-1] ? W'(-zr_r) : W'(zr_r);
    zi_mag       = zi_r[W-1] ? W'(-zi_r) : W'(zi_r);
    ur           = zr_mag[MW-1:0];
    ui           = zi_mag[MW-1:0];
    p_rr         = ur * ur;
    p_ii         = ui * ui;
    p_ri         = ur * ui;
  end

  // Escape test on the truncated squares and the saturating update.
  always_comb begin
    sum_sq = {1'b0, sr_r} + {1'b0, si_r};
    xc     = $signed({{(EW-XW){1'b0}}, cross_r});
    if (xneg_r) begin
      xc = -xc;
    end
    zr_sum = $signed({{(EW-SW){1'b0}}, sr_r}) - $signed({{(EW-SW){1'b0}}, si_r})
           + EW'(cr_r);
    zi_sum = xc - EW'(ci_r);
    if (zr_sum > VMAX) begin
      zr_nxt = VMAX[W-1:0];
    end else if (zr_sum < VMIN) begin
      zr_nxt = VMIN[W-1:0];
    end else begin
      zr_nxt = zr_sum[W-1:0];
    end
    if (zi_sum > VMAX) begin
      zi_nxt = VMAX[W-1:0];
    end else if (zi_sum < VMIN) begin
      zi_nxt = VMIN[W-1:0];
    end else begin
      zi_nxt = zi_sum[W-1:0];
    end
  end

  // Status back to the sequencer.
  assign st.stop     = limit_hit || out_of_range;
  assign st.sum_esc  = (sum_sq > FOUR);
  assign st.out_free = !out_valid_r || !out_stall;

  // Working registers.
  always_ff @(posedge clk) begin
    if (load) begin
      cr_r  <= in_c_real;
      ci_r  <= in_c_imag;
      zr_r  <= '0;
      zi_r  <= '0;
      n_r   <= '0;
      esc_r <= 1'b0;
    end
    if (cw.mul_en) begin
      sr_r    <= p_rr[2*MW-1:F];
      si_r    <= p_ii[2*MW-1:F];
      cross_r <= p_ri[2*MW-1:F-1];
      xneg_r  <= zr_r[W-1] ^ zi_r[W-1];
      if (st.stop) begin
        esc_r <= !limit_hit;
      end
    end
    if (cw.upd_en) begin
      if (st.sum_esc) begin
        esc_r <= 1'b1;
      end else begin
        zr_r <= zr_nxt;
        zi_r <= zi_nxt;
        n_r  <= n_r + 1'b1;
      end
    end
    if (emit_go) begin
      out_count_r <= n_r;
      out_esc_r   <= esc_r;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_iteration_count = out_count_r;
  assign out_escaped         = out_esc_r;

`ifndef NO_ASSERTIONS
  // The step count never passes the limit while a point is being iterated.
  a_count_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    cw.mul_en |-> (n_r <= max_iter))
    else $error("step count passed the iteration limit");

  // A point that did not escape has used up the whole limit.
  a_inside_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_go && !esc_r) |-> (n_r == max_iter))
    else $error("non-escaped result with a short count");
`endif

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the fixed-point escape-time unit mandelbrot_escape_time.
// Depends on mbe_pkg and the unit's RTL; it predicts every result on its own.
module tb
  import mbe_pkg::*;
();

  localparam int unsigned VALUE_WIDTH   = 32;
  localparam int unsigned FRACTION_BITS = 28;

  // Handy fixed-point values: one, and the extremes of a field.
  localparam int ONE = 1 << FRACTION_BITS;
  localparam logic signed [VALUE_WIDTH-1:0] VMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [VALUE_WIDTH-1:0] VMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic [LIMIT_W-1:0] count;
    logic               escaped;
  } escape_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic signed [VALUE_WIDTH-1:0] in_c_real = '0;
  logic signed [VALUE_WIDTH-1:0] in_c_imag = '0;
  logic out_stall = 1'b0;
  logic cfg_valid = 1'b0;
  logic [LIMIT_W-1:0] cfg_wdata = '0;
  logic in_stall;
  logic out_valid;
  logic [LIMIT_W-1:0] out_iteration_count;
  logic out_escaped;
  logic cfg_ready;

  escape_result_t expected_results[$];
  logic [LIMIT_W-1:0] limit_model = LIMIT_RESET;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned error_count = 0;

  mandelbrot_escape_time #(
    .VALUE_WIDTH  (VALUE_WIDTH),
    .FRACTION_BITS(FRACTION_BITS)
  ) DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_c_real          (in_c_real),
    .in_c_imag          (in_c_imag),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_iteration_count(out_iteration_count),
    .out_escaped        (out_escaped),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_wdata          (cfg_wdata)
  );

  always #4 clk = ~clk;

  // Clamp a wide value to the signed range of one field.
  function automatic longint clamp_value(input longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (VALUE_WIDTH - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Run the iteration for one point: squares of magnitudes truncated to the
  // fraction width, the imaginary part of c subtracted, new z saturated.
  function automatic escape_result_t predict_escape(input logic signed [VALUE_WIDTH-1:0] re,
                                                    input logic signed [VALUE_WIDTH-1:0] im,
                                                    input logic [LIMIT_W-1:0] limit);
    escape_result_t res;
    longint zr;
    longint zi;
    longint xc;
    longint two;
    longint unsigned ur;
    longint unsigned ui;
    longint unsigned sr;
    longint unsigned si;
    longint unsigned four;
    int unsigned n;
    logic esc;
    zr = 0;
    zi = 0;
    n = 0;
    esc = 1'b0;
    two = longint'(1) <<< (FRACTION_BITS + 1);
    four = longint'(1) <<< (FRACTION_BITS + 2);
    while (n < limit) begin
      // A part beyond two in magnitude escapes before any product is formed.
      if (zr > two || zr < -two || zi > two || zi < -two) begin
        esc = 1'b1;
        break;
      end
      ur = (zr < 0) ? longint'(-zr) : longint'(zr);
      ui = (zi < 0) ? longint'(-zi) : longint'(zi);
      sr = (ur * ur) >> FRACTION_BITS;
      si = (ui * ui) >> FRACTION_BITS;
      if (sr + si > four) begin
        esc = 1'b1;
        break;
      end
      xc = longint'((ur * ui) >> (FRACTION_BITS - 1));
      if ((zr < 0) != (zi < 0)) xc = -xc;
      zi = clamp_value(xc - longint'(im));
      zr = clamp_value(longint'(sr) - longint'(si) + longint'(re));
      n++;
    end
    res.count = n[LIMIT_W-1:0];
    res.escaped = esc;
    return res;
  endfunction

  task automatic report_error(input string msg);
    $display("%0t ERROR: %s", $time, msg);
    error_count++;
  endtask

  // Present one point and record its expected result once the request is taken.
  task automatic send_point(input logic signed [VALUE_WIDTH-1:0] re,
                            input logic signed [VALUE_WIDTH-1:0] im);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_c_real <= re;
    in_c_imag <= im;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_results.push_back(predict_escape(re, im, limit_model));
  endtask

  // Let every outstanding result come back.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Write the iteration limit once the unit is idle.
  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    wait_for_results();
    cfg_valid <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    limit_model = value;
  endtask

  // Receiver stalls at random at the chosen rate.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin : check_results
    escape_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_error($sformatf("unexpected result: count %0d escaped %0b",
                               out_iteration_count, out_escaped));
      end else begin
        want = expected_results.pop_front();
        if (out_iteration_count !== want.count)
          report_error($sformatf("iteration_count %0d, expected %0d",
                                 out_iteration_count, want.count));
        if (out_escaped !== want.escaped)
          report_error($sformatf("escaped %b, expected %b", out_escaped, want.escaped));
      end
    end
  end

  // Field extremes and the corner cases of the iteration at the reset limit.
  task automatic test_directed_points();
    send_point(0, 0);                   // never escapes
    send_point(VMAX, VMAX);
    send_point(VMIN, VMIN);             // negating c_imag saturates z
    send_point(VMIN, VMAX);
    send_point(VMAX, VMIN);
    send_point(-2 * ONE, 0);            // |z|^2 sits exactly on four
    send_point(2 * ONE, 0);             // on two, escapes on the next step
    send_point(0, 2 * ONE);
    send_point(3 * ONE, 0);             // part of z beyond two at once
    send_point(0, -3 * ONE);
    send_point(ONE / 4, 0);             // cusp: slow convergence
    send_point(ONE / 4 + ONE / 100, 0); // just outside the cusp
    send_point(-ONE, 0);                // z alternates between 0 and -1
    send_point(0, ONE);                 // preperiodic point
    send_point(-(ONE / 2), -(ONE / 2));
    send_point(-ONE * 3 / 4, ONE / 10);
    send_point(ONE * 3 / 10, ONE / 2);
    send_point(-1, 1);                  // one LSB either side of zero
    send_point(-ONE, -1);
    send_point(-ONE * 5 / 4, 0);
  endtask

  // Zero limit, a single step, and the largest limit.
  task automatic test_limit_extremes();
    write_limit('0);
    send_point(0, 0);
    send_point(VMAX, VMAX);
    write_limit(LIMIT_W'(1));
    send_point(0, 0);
    send_point(3 * ONE, 0);
    send_point(VMIN, VMIN);
    write_limit('1);
    send_point(0, 0);
    send_point(ONE / 4 + ONE / 1000, 0);
    send_point(VMIN, 0);
  endtask

  // Random points: mostly inside the region where the iteration runs for a
  // while, the rest anywhere in the full range of the fields.
  task automatic test_random_points(input int unsigned count,
                                    input logic [LIMIT_W-1:0] limit,
                                    input int unsigned idle_pct,
                                    input int unsigned stall_pct);
    int unsigned kind;
    logic signed [VALUE_WIDTH-1:0] re;
    logic signed [VALUE_WIDTH-1:0] im;
    write_limit(limit);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int unsigned i = 0; i < count; i++) begin
      kind = $urandom_range(99);
      if (kind < 55) begin
        re = $urandom_range(0, 3 * ONE) - (ONE * 9 / 4);
        im = $urandom_range(0, 3 * ONE) - (ONE * 3 / 2);
      end else if (kind < 80) begin
        re = $urandom_range(0, ONE) - (ONE * 3 / 4);
        im = $urandom_range(0, ONE) - (ONE / 2);
      end else begin
        re = $urandom;
        im = $urandom;
      end
      send_point(re, im);
    end
  endtask

  initial begin
    int unsigned tail;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct  = 9;
    recv_stall_pct = 78;
    test_directed_points();
    test_limit_extremes();
    test_random_points(200, 16'd255, 9, 78);
    test_random_points(200, 16'd40, 78, 9);
    test_random_points(200, 16'd511, 0, 0);
    wait_for_results();
    // Give a stray result time to show up.
    tail = 2 * limit_model + 16;
    if (tail > 4096) tail = 4096;
    repeat (tail) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
